/* rtl/flash_log_key_store_unit_assert.svh */
// Assertion macros for the flash log key store.
// Included by the modules that carry concurrent checks.
`ifndef FLASH_LOG_KEY_STORE_UNIT_ASSERT_SVH
`define FLASH_LOG_KEY_STORE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define FLKS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`else
`define FLKS_ASSERT(label, clk, rst, prop, msg)
`endif
`ifndef SYNTHESIS
`define FLKS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define FLKS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

/* rtl/flks_pkg.sv */
// Shared types and constants for the flash log key store.
// No dependencies.
package flks_pkg;
  localparam int PageBytes = 1024;
  localparam int TotalBytes = 2 * PageBytes;
  localparam int AddrW = $clog2(TotalBytes);
  localparam int OffW = $clog2(PageBytes);
  localparam int MaxPkt = 16;
  localparam logic [7:0] ErasedByte = 8'hFF;
  localparam logic [7:0] BlankByte = 8'h00;
  localparam logic [1:0] OpInit = 2'd0;
  localparam logic [1:0] OpStore = 2'd1;
  localparam logic [1:0] OpLoad = 2'd2;
  localparam logic [1:0] RegSizeOne = 2'd0;
  localparam logic [1:0] RegSizeTwo = 2'd1;
  localparam logic [1:0] RegSizeThree = 2'd2;

  typedef struct packed {
    logic [63:0] data_hi;
    logic [63:0] data_lo;
    logic [1:0] key;
    logic [1:0] opcode;
  } in_item_t;

  typedef struct packed {
    logic [10:0] free_offset;
    logic active_page;
    logic page_switched;
    logic status;
    logic found;
    logic [63:0] out_hi;
    logic [63:0] out_lo;
  } out_item_t;

  // Clamp to 2..16 and round down to even.
  function automatic logic [4:0] clamp_size(input logic [4:0] s);
    logic [4:0] r;
    r = s;
    if (r > 5'd16) r = 5'd16;
    if (r < 5'd2) r = 5'd2;
    return {r[4:1], 1'b0};
  endfunction
endpackage

/* rtl/flash_log_key_store_unit.sv */
// Top level of the flash log key store: sequencer over a byte-wide image memory.
// Depends on flks_pkg and flash_log_key_store_unit_assert.svh.
// A page switch on a store adds up to two page erases and a copy of every live packet.
// Init erases at most one page, then scans the headers of the active page. One item at a time.
// Reset starts a pass that writes 0x00 over the image; no item is accepted.
`include "flash_log_key_store_unit_assert.svh"
module flash_log_key_store_unit import flks_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_item_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_item_t out_data,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [4:0] cfg_data
);
  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_INIT_RD, S_INIT_RD2, S_INIT_RD3, S_INIT_CHK, S_ERASE,
    S_SCAN_RD, S_SCAN_CHK, S_SCAN_DONE, S_WR, S_LD_RD, S_LD_CAP, S_SW_RD,
    S_SW_CHK, S_CP_NEXT, S_CP_RD, S_CP_CAP, S_CP_WR, S_SW_END, S_RESULT
  } state_t;
  typedef enum logic [1:0] {ER_INIT, ER_NEW, ER_OLD} er_t;

  logic [7:0] mem [TotalBytes];
  logic [7:0] rd_q;
  logic [AddrW-1:0] addr;
  logic we;
  logic [7:0] wdata;

  state_t state;
  er_t er_kind;
  logic [4:0] size_one, size_two, size_three;
  logic [AddrW-1:0] loc [1:3];
  logic [3:1] present;
  logic [AddrW-1:0] free_ptr;
  logic page;
  logic [AddrW:0] cnt;
  logic [AddrW-1:0] base;
  logic [OffW:0] j;
  logic [1:0] key, ck;
  logic [7:0] pkt [MaxPkt];
  logic [7:0] copy_buf [MaxPkt];
  logic [4:0] bi;
  logic switched;
  out_item_t res;
  logic [4:0] sz_key, sz_ck, sz_h;

  function automatic logic [4:0] size_of(input logic [1:0] k, input logic [4:0] a,
                                         input logic [4:0] b, input logic [4:0] c);
    logic [4:0] s;
    unique case (k)
      2'd1: s = a;
      2'd2: s = b;
      default: s = c;
    endcase
    return clamp_size(s);
  endfunction

  always_comb begin
    sz_key = size_of(key, size_one, size_two, size_three);
    sz_ck = size_of(ck, size_one, size_two, size_three);
    sz_h = size_of(rd_q[1:0], size_one, size_two, size_three);
  end

  always_comb begin
    we = 1'b0;
    wdata = ErasedByte;
    addr = free_ptr;
    unique case (state)
      S_CLEAR: begin
        we = 1'b1; wdata = BlankByte; addr = cnt[AddrW-1:0];
      end
      S_ERASE: begin
        we = 1'b1; addr = base + AddrW'(cnt[OffW-1:0]);
      end
      S_INIT_RD: addr = AddrW'(PageBytes);
      S_INIT_RD3: addr = base;
      S_SCAN_RD: addr = base + AddrW'(j[OffW-1:0]);
      S_WR: begin
        we = 1'b1; wdata = pkt[bi[3:0]]; addr = free_ptr + AddrW'(bi);
      end
      S_LD_RD: addr = loc[key] + AddrW'(bi);
      S_SW_RD: addr = base;
      S_CP_RD: addr = loc[ck] + AddrW'(bi);
      S_CP_WR: begin
        we = 1'b1; wdata = copy_buf[bi[3:0]]; addr = free_ptr + AddrW'(bi);
      end
      default: addr = free_ptr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rd_q <= mem[addr];
  end

  assign in_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = (state == S_RESULT);

  // The state fields of a result come straight from the live registers.
  always_comb begin
    out_data = res;
    out_data.page_switched = switched;
    out_data.active_page = page;
    out_data.free_offset = free_ptr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt <= '0;
      present <= '0;
      loc[1] <= '0; loc[2] <= '0; loc[3] <= '0;
      free_ptr <= '0;
      page <= 1'b0;
      size_one <= 5'd4; size_two <= 5'd16; size_three <= 5'd4;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          RegSizeOne: size_one <= cfg_data;
          RegSizeTwo: size_two <= cfg_data;
          RegSizeThree: size_three <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == (AddrW+1)'(TotalBytes - 1)) state <= S_IDLE;
        end
        S_IDLE: if (in_valid) begin
          key <= in_data.key; bi <= '0; switched <= 1'b0;
          for (int i = 0; i < 8; i++) begin
            pkt[i] <= in_data.data_lo[8*i +: 8];
            pkt[i+8] <= in_data.data_hi[8*i +: 8];
          end
          res.out_lo <= '0;
          res.out_hi <= '0;
          res.found <= 1'b0;
          res.page_switched <= 1'b0;
          res.active_page <= 1'b0;
          res.free_offset <= '0;
          res.status <= (in_data.opcode == OpStore || in_data.opcode == OpLoad)
                        && in_data.key == 2'd0;
          priority if (in_data.opcode == OpInit) state <= S_INIT_RD;
          else if ((in_data.opcode == OpStore || in_data.opcode == OpLoad)
                   && in_data.key == 2'd0) begin
            state <= S_RESULT;
          end else if (in_data.opcode == OpLoad) state <= S_LD_RD;
          else if (in_data.opcode == OpStore) state <= S_SW_CHK;
          else state <= S_RESULT;
        end
        S_INIT_RD: state <= S_INIT_RD2;
        S_INIT_RD2: begin
          page <= !(rd_q == BlankByte || rd_q == ErasedByte);
          base <= (rd_q == BlankByte || rd_q == ErasedByte) ? '0 : AddrW'(PageBytes);
          state <= S_INIT_RD3;
        end
        S_INIT_RD3: state <= S_INIT_CHK;
        S_INIT_CHK: begin
          present <= '0;
          loc[1] <= '0; loc[2] <= '0; loc[3] <= '0;
          j <= '0; cnt <= '0; er_kind <= ER_INIT;
          state <= (rd_q == BlankByte) ? S_ERASE : S_SCAN_RD;
        end
        S_ERASE: begin
          cnt <= cnt + 1'b1;
          if (cnt[OffW-1:0] == OffW'(PageBytes - 1)) begin
            unique case (er_kind)
              ER_INIT: state <= S_SCAN_RD;
              ER_NEW: begin ck <= 2'd0; state <= S_CP_NEXT; end
              default: state <= S_SW_END;
            endcase
          end
        end
        S_SCAN_RD: state <= S_SCAN_CHK;
        S_SCAN_CHK: begin
          if (rd_q == ErasedByte) state <= S_SCAN_DONE;
          else begin
            if (rd_q >= 8'd1 && rd_q <= 8'd3) begin
              loc[rd_q[1:0]] <= base + AddrW'(j[OffW-1:0]);
              present[rd_q[1:0]] <= 1'b1;
              j <= j + (OffW+1)'(sz_h);
              if (j + (OffW+1)'(sz_h) >= (OffW+1)'(PageBytes)) state <= S_SCAN_DONE;
              else state <= S_SCAN_RD;
            end else begin
              j <= j + (OffW+1)'(4);
              if (j + (OffW+1)'(4) >= (OffW+1)'(PageBytes)) state <= S_SCAN_DONE;
              else state <= S_SCAN_RD;
            end
          end
        end
        S_SCAN_DONE: begin
          if (j < (OffW+1)'(PageBytes)) free_ptr <= base + AddrW'(j[OffW-1:0]);
          else free_ptr <= page ? '0 : AddrW'(PageBytes);
          state <= S_RESULT;
        end
        S_SW_CHK: begin
          if ((OffW+1)'(free_ptr[OffW-1:0]) + (OffW+1)'(sz_key) >= (OffW+1)'(PageBytes)) begin
            base <= page ? '0 : AddrW'(PageBytes);
            switched <= 1'b1;
            ck <= 2'd0;
            state <= S_SW_RD;
          end else state <= S_WR;
        end
        S_SW_RD: state <= S_CP_CAP;
        S_CP_CAP: begin
          // Reused as the wait for the switch header read when ck is zero.
          if (ck == 2'd0) begin
            free_ptr <= base; cnt <= '0; er_kind <= ER_NEW;
            state <= (rd_q != ErasedByte) ? S_ERASE : S_CP_NEXT;
          end else begin
            copy_buf[bi[3:0]] <= rd_q;
            if (bi + 1'b1 == sz_ck) begin bi <= '0; state <= S_CP_WR; end
            else begin bi <= bi + 1'b1; state <= S_CP_RD; end
          end
        end
        S_CP_NEXT: begin
          bi <= '0;
          if (ck == 2'd3) begin
            cnt <= '0; er_kind <= ER_OLD; base <= page ? AddrW'(PageBytes) : '0;
            state <= S_ERASE;
          end else begin
            ck <= ck + 1'b1;
            state <= present[ck + 1'b1] ? S_CP_RD : S_CP_NEXT;
          end
        end
        S_CP_RD: state <= S_CP_CAP;
        S_CP_WR: begin
          if (bi + 1'b1 == sz_ck) begin
            loc[ck] <= free_ptr;
            free_ptr <= free_ptr + AddrW'(sz_ck);
            bi <= '0;
            state <= S_CP_NEXT;
          end else bi <= bi + 1'b1;
        end
        S_SW_END: begin
          page <= ~page;
          bi <= '0;
          state <= S_WR;
        end
        S_WR: begin
          if (bi + 1'b1 == sz_key) begin
            loc[key] <= free_ptr;
            present[key] <= 1'b1;
            free_ptr <= free_ptr + AddrW'(sz_key);
            state <= S_RESULT;
          end else bi <= bi + 1'b1;
        end
        S_LD_RD: state <= S_LD_CAP;
        S_LD_CAP: begin
          if (!present[key]) begin
            res.out_lo <= {56'd0, 6'd0, key};
            state <= S_RESULT;
          end else begin
            res.found <= 1'b1;
            if (bi < 5'd8) res.out_lo[8*bi[2:0] +: 8] <= rd_q;
            else res.out_hi[8*bi[2:0] +: 8] <= rd_q;
            if (bi + 1'b1 == sz_key) state <= S_RESULT;
            else begin bi <= bi + 1'b1; state <= S_LD_RD; end
          end
        end
        S_RESULT: begin
          if (!out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `FLKS_ASSERT(a_stall_busy, clk, rst, (state != S_IDLE) |-> in_stall, "busy but not stalled")
  `FLKS_ASSERT(a_out_only_result, clk, rst, out_valid |-> in_stall, "result while accepting")
  `FLKS_ASSERT(a_pick_size, clk, rst, (state == S_WR) |-> (sz_key >= 5'd2), "bad size")
endmodule
